// File: rtl/bpfr_pkg.sv
// ----------------------------------------------------------------------------
// bpfr_pkg: shared types and constants of the buffer pool frame replacer
// Default sizes, field widths, function codes, status codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfr_pkg;

  localparam int NUM_FRAMES_DEF = 16;
  localparam int PAGE_BITS_DEF  = 20;
  localparam int PIN_BITS_DEF   = 8;

  localparam int FUNC_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int SEL_W     = 4;
  localparam int OPAGE_W   = 20;
  localparam int OPINS_W   = 8;
  localparam int COUNT_W   = 32;

  localparam logic [FUNC_W-1:0] FN_PIN     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_UNPIN   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DIRTY   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FORCE   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_FLUSH   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_INSPECT = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FRAME = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_ACT,
    S_REREAD,
    S_RESCAN,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// File: rtl/bpfr_table.sv
// ----------------------------------------------------------------------------
// bpfr_table: frame table memory
// One read port with registered data and one write port; reset clears the
// per-frame valid bits so an unwritten frame reads as empty.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfr_table #(
  parameter int NUM_FRAMES = bpfr_pkg::NUM_FRAMES_DEF,
  parameter int ENTRY_W    = 32,
  parameter int IDX_W      = 4
) (
  input  wire                clk,
  input  wire                rst,
  input  wire  [IDX_W-1:0]   rd_addr,
  output logic [ENTRY_W-1:0] rd_data,
  input  wire                wr_en,
  input  wire  [IDX_W-1:0]   wr_addr,
  input  wire  [ENTRY_W-1:0] wr_data
);

  logic [ENTRY_W-1:0]    mem [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] valid;
  logic [ENTRY_W-1:0]    rd_raw;
  logic                  rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_raw <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

`default_nettype wire

// File: rtl/buffer_pool_frame_replacer.sv
// ----------------------------------------------------------------------------
// buffer_pool_frame_replacer: page buffer pool frame table with FIFO/LRU
// Looks up pages, pins and unpins frames, picks victims and reports the disk
// transfers that each request implies.
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | payload
//  s_axis  | in  | tvalid/tready   | func, page_num, frame_sel
//  m_axis  | out | tvalid/tready   | status .. io_writes
//  cfg     | in  | cfg_valid/ready | replacement_policy
//
// A request is taken in the idle state, which also issues the read of frame 0.
// The sweep then goes over the returning entries to find the hit, the lowest
// empty frame and the lowest-rank unpinned frame. A decide cycle reads the
// target frame and an act cycle updates it and loads the result item. A pin
// that changes ranks (LRU hit or eviction) sweeps once more to rewrite the
// ranks before the next request is taken. A flush gives one result item for
// each frame that it writes back, and none when there is nothing to write
// back. All frame state lives in one memory with registered read data; the
// sweeps issue the next address while the previous data returns. Reset clears
// the table's valid bits at once, so there is no clearing pass. A stalled
// output holds the sequencer in its emit state, and no request is taken while
// a result item waits.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_pool_frame_replacer #(
  parameter int NUM_FRAMES = bpfr_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_BITS  = bpfr_pkg::PAGE_BITS_DEF,
  parameter int PIN_BITS   = bpfr_pkg::PIN_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // [2:0] func, [22:3] page_num, [26:23] frame_sel, zero filled to 32 bits
  input  wire  [31:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // [1:0] status, [5:2] frame_used, [6] writeback_valid, [26:7] writeback_page,
  // [27] fetch_valid, [47:28] fetch_page, [48] frame_occupied,
  // [68:49] frame_page, [76:69] frame_pins, [77] frame_dirty,
  // [109:78] io_reads, [141:110] io_writes, zero filled to 144 bits
  output logic [143:0] m_axis_tdata,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire          cfg_data
);

  localparam int IDX_W  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CNT_W  = $clog2(NUM_FRAMES + 1);
  localparam int RANK_W = IDX_W;
  // Entry: occupied, dirty, pins, rank, page.
  localparam int ENTRY_W = 2 + PIN_BITS + RANK_W + PAGE_BITS;
  localparam int P_LO = 0;
  localparam int R_LO = PAGE_BITS;
  localparam int N_LO = PAGE_BITS + RANK_W;
  localparam int D_B  = PAGE_BITS + RANK_W + PIN_BITS;
  localparam int O_B  = D_B + 1;
  localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};
  localparam int OW = bpfr_pkg::OPAGE_W;

  // Request fields.
  logic [bpfr_pkg::FUNC_W-1:0] func;
  logic [PAGE_BITS-1:0]        page;
  logic [bpfr_pkg::SEL_W-1:0]  sel;

  bpfr_pkg::state_t state, state_next;

  logic                  policy;
  logic [CNT_W-1:0]      filled;
  logic [31:0]           reads, writes;

  // Sweep counters: issue address and returning-data index.
  logic [CNT_W-1:0] scan_cnt;
  logic [IDX_W-1:0] data_idx;
  logic             data_live;

  // Sweep findings.
  logic             hit_found, empty_found, victim_found;
  logic [IDX_W-1:0] hit_idx, empty_idx, victim_idx;
  logic [RANK_W-1:0] victim_rank;

  // Target frame and its entry, and the rank it leaves.
  logic [IDX_W-1:0]   tgt;
  logic [ENTRY_W-1:0] tgt_entry;
  logic [RANK_W-1:0]  old_rank;
  logic [RANK_W-1:0]  new_rank;

  // Table ports.
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  // Result register.
  logic [143:0] res;
  logic         res_valid;

  bpfr_table #(
    .NUM_FRAMES(NUM_FRAMES),
    .ENTRY_W   (ENTRY_W),
    .IDX_W     (IDX_W)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  logic              e_occ, e_dirty;
  logic [PIN_BITS-1:0] e_pins;
  logic [RANK_W-1:0] e_rank;
  logic [PAGE_BITS-1:0] e_page;
  assign e_occ   = rd_data[O_B];
  assign e_dirty = rd_data[D_B];
  assign e_pins  = rd_data[N_LO +: PIN_BITS];
  assign e_rank  = rd_data[R_LO +: RANK_W];
  assign e_page  = rd_data[P_LO +: PAGE_BITS];

  // The decide cycle reads the target frame, so its entry is on the read
  // data during the act cycle.
  assign tgt_entry = rd_data;

  logic scan_done;
  assign scan_done = (scan_cnt == CNT_W'(NUM_FRAMES));

  assign s_axis_tready = (state == bpfr_pkg::S_IDLE) && !res_valid;
  assign cfg_ready     = (state == bpfr_pkg::S_IDLE) && !res_valid;
  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = res;

  // A frame during the flush sweep that must be written back.
  logic flush_hit;
  assign flush_hit = data_live && e_occ && e_dirty && (e_pins == '0);

  logic is_pin, pin_evict, pin_fill, pin_hit, rank_change;
  assign is_pin    = (func == bpfr_pkg::FN_PIN);
  assign pin_hit   = is_pin && hit_found;
  assign pin_fill  = is_pin && !hit_found && empty_found;
  assign pin_evict = is_pin && !hit_found && !empty_found && victim_found;
  assign rank_change = (pin_hit && policy) || pin_evict;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      bpfr_pkg::S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          if (s_axis_tdata[2:0] > bpfr_pkg::FN_INSPECT) begin
            state_next = bpfr_pkg::S_IDLE;
          end else begin
            state_next = bpfr_pkg::S_SCAN;
          end
        end
      end
      bpfr_pkg::S_SCAN: begin
        if (func == bpfr_pkg::FN_FLUSH && flush_hit) begin
          state_next = bpfr_pkg::S_EMIT;
        end else if (scan_done && !data_live) begin
          state_next = (func == bpfr_pkg::FN_FLUSH) ? bpfr_pkg::S_IDLE
                                                    : bpfr_pkg::S_DECIDE;
        end else if (scan_done && data_live && data_idx == IDX_W'(NUM_FRAMES - 1)) begin
          state_next = (func == bpfr_pkg::FN_FLUSH) ? bpfr_pkg::S_IDLE
                                                    : bpfr_pkg::S_DECIDE;
        end
      end
      bpfr_pkg::S_DECIDE: state_next = bpfr_pkg::S_ACT;
      bpfr_pkg::S_ACT: begin
        state_next = rank_change ? bpfr_pkg::S_RESCAN : bpfr_pkg::S_EMIT;
      end
      bpfr_pkg::S_RESCAN: begin
        if (data_live && data_idx == IDX_W'(NUM_FRAMES - 1)) begin
          state_next = bpfr_pkg::S_EMIT;
        end
      end
      bpfr_pkg::S_REREAD: state_next = bpfr_pkg::S_SCAN;
      bpfr_pkg::S_EMIT: begin
        if (!res_valid) begin
          state_next = (func == bpfr_pkg::FN_FLUSH) ? bpfr_pkg::S_REREAD
                                                    : bpfr_pkg::S_IDLE;
        end
      end
      default: state_next = bpfr_pkg::S_IDLE;
    endcase
  end

  // Memory access control.
  logic [PIN_BITS-1:0] t_pins;
  assign t_pins = tgt_entry[N_LO +: PIN_BITS];

  always_comb begin
    rd_addr = scan_cnt[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = tgt;
    wr_data = tgt_entry;
    case (state)
      bpfr_pkg::S_IDLE: begin
        // A taken request always starts its sweep at frame 0.
        rd_addr = '0;
      end
      bpfr_pkg::S_DECIDE: begin
        rd_addr = tgt;
      end
      bpfr_pkg::S_SCAN: begin
        if (func == bpfr_pkg::FN_FLUSH && flush_hit) begin
          wr_en   = 1'b1;
          wr_addr = data_idx;
          wr_data = rd_data;
          wr_data[D_B] = 1'b0;
        end
      end
      bpfr_pkg::S_ACT: begin
        rd_addr = '0;
        wr_data = tgt_entry;
        case (func)
          bpfr_pkg::FN_PIN: begin
            wr_en = hit_found || empty_found || victim_found;
            if (hit_found) begin
              if (t_pins != PIN_MAX) begin
                wr_data[N_LO +: PIN_BITS] = t_pins + PIN_BITS'(1);
              end
              if (policy) begin
                wr_data[R_LO +: RANK_W] = new_rank;
              end
            end else begin
              wr_data[O_B] = 1'b1;
              wr_data[D_B] = 1'b0;
              wr_data[N_LO +: PIN_BITS] = PIN_BITS'(1);
              wr_data[P_LO +: PAGE_BITS] = page;
              wr_data[R_LO +: RANK_W] = new_rank;
            end
          end
          bpfr_pkg::FN_UNPIN: begin
            wr_en = hit_found;
            if (t_pins != '0) begin
              wr_data[N_LO +: PIN_BITS] = t_pins - PIN_BITS'(1);
            end
          end
          bpfr_pkg::FN_DIRTY: begin
            wr_en = hit_found;
            wr_data[D_B] = 1'b1;
          end
          bpfr_pkg::FN_FORCE: begin
            wr_en = hit_found;
            wr_data[D_B] = 1'b0;
          end
          default: wr_en = 1'b0;
        endcase
      end
      bpfr_pkg::S_RESCAN: begin
        // Frames above the promoted frame's old rank move down by one.
        if (data_live && data_idx != tgt && e_occ && e_rank > old_rank) begin
          wr_en   = 1'b1;
          wr_addr = data_idx;
          wr_data = rd_data;
          wr_data[R_LO +: RANK_W] = e_rank - RANK_W'(1);
        end
      end
      default: rd_addr = scan_cnt[IDX_W-1:0];
    endcase
  end

  // Outputs of a result.
  logic [143:0] res_next;
  logic         res_load;
  logic [31:0]  reads_next, writes_next;

  always_comb begin
    res_next    = '0;
    res_load    = 1'b0;
    reads_next  = reads;
    writes_next = writes;
    if (state == bpfr_pkg::S_SCAN && func == bpfr_pkg::FN_FLUSH && flush_hit) begin
      writes_next   = writes + 32'd1;
      res_load      = 1'b1;
      res_next[5:2] = 4'(data_idx);
      res_next[6]   = 1'b1;
      res_next[26:7] = OW'(e_page);
    end else if (state == bpfr_pkg::S_ACT) begin
      res_load = 1'b1;
      case (func)
        bpfr_pkg::FN_PIN: begin
          if (hit_found) begin
            res_next[5:2] = 4'(tgt);
          end else if (!empty_found && !victim_found) begin
            res_next[1:0] = bpfr_pkg::ST_NO_FRAME;
          end else begin
            reads_next     = reads + 32'd1;
            res_next[5:2]  = 4'(tgt);
            res_next[27]   = 1'b1;
            res_next[47:28] = OW'(page);
            if (pin_evict && tgt_entry[D_B]) begin
              writes_next    = writes + 32'd1;
              res_next[6]    = 1'b1;
              res_next[26:7] = OW'(tgt_entry[P_LO +: PAGE_BITS]);
            end
          end
        end
        bpfr_pkg::FN_INSPECT: begin
          res_next[5:2] = sel;
          if (32'(sel) < 32'(NUM_FRAMES) && tgt_entry[O_B]) begin
            res_next[48]    = 1'b1;
            res_next[68:49] = OW'(tgt_entry[P_LO +: PAGE_BITS]);
            res_next[76:69] = bpfr_pkg::OPINS_W'(t_pins);
            res_next[77]    = tgt_entry[D_B];
          end
        end
        default: begin
          if (!hit_found) begin
            if (func == bpfr_pkg::FN_UNPIN) begin
              res_next[1:0] = bpfr_pkg::ST_MISSING;
            end
          end else begin
            res_next[5:2] = 4'(tgt);
            if (func == bpfr_pkg::FN_FORCE) begin
              writes_next    = writes + 32'd1;
              res_next[6]    = 1'b1;
              res_next[26:7] = OW'(tgt_entry[P_LO +: PAGE_BITS]);
            end
          end
        end
      endcase
    end
    res_next[109:78]  = reads_next;
    res_next[141:110] = writes_next;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpfr_pkg::S_IDLE;
      policy    <= 1'b0;
      filled    <= '0;
      reads     <= '0;
      writes    <= '0;
      res_valid <= 1'b0;
      scan_cnt  <= '0;
      data_live <= 1'b0;
    end else begin
      state  <= state_next;
      reads  <= reads_next;
      writes <= writes_next;
      if (cfg_valid && cfg_ready) begin
        policy <= cfg_data;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        res_valid <= 1'b0;
      end
      if (state == bpfr_pkg::S_ACT && pin_fill) begin
        filled <= filled + CNT_W'(1);
      end
      // Sweep address generation: paused when a flush frame is found.
      case (state)
        bpfr_pkg::S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            scan_cnt  <= CNT_W'(1);
            data_live <= 1'b1;
          end else begin
            scan_cnt  <= '0;
            data_live <= 1'b0;
          end
        end
        bpfr_pkg::S_SCAN: begin
          if (func == bpfr_pkg::FN_FLUSH && flush_hit) begin
            data_live <= 1'b0;
          end else if (!scan_done) begin
            scan_cnt  <= scan_cnt + CNT_W'(1);
            data_live <= 1'b1;
          end else begin
            data_live <= 1'b0;
          end
        end
        bpfr_pkg::S_ACT: begin
          scan_cnt  <= CNT_W'(1);
          data_live <= 1'b1;
        end
        bpfr_pkg::S_RESCAN: begin
          if (!scan_done) begin
            scan_cnt <= scan_cnt + CNT_W'(1);
          end
          data_live <= !scan_done;
        end
        bpfr_pkg::S_REREAD: begin
          // Re-issue the address after the flushed frame.
          if (!scan_done) begin
            scan_cnt  <= scan_cnt + CNT_W'(1);
            data_live <= 1'b1;
          end else begin
            data_live <= 1'b0;
          end
        end
        default: data_live <= 1'b0;
      endcase
    end
  end

  // Data registers: sweep findings and the rank that the target leaves.
  always_ff @(posedge clk) begin
    if (state == bpfr_pkg::S_IDLE && s_axis_tvalid && s_axis_tready) begin
      func         <= s_axis_tdata[2:0];
      page         <= PAGE_BITS'(s_axis_tdata[22:3]);
      sel          <= s_axis_tdata[26:23];
      hit_found    <= 1'b0;
      empty_found  <= 1'b0;
      victim_found <= 1'b0;
      hit_idx      <= '0;
      empty_idx    <= '0;
      victim_idx   <= '0;
      victim_rank  <= '0;
    end
    if (state == bpfr_pkg::S_IDLE || state == bpfr_pkg::S_ACT) begin
      data_idx <= '0;
    end else if (state == bpfr_pkg::S_REREAD) begin
      data_idx <= data_idx + IDX_W'(1);
    end else if (data_live && !(state == bpfr_pkg::S_SCAN &&
                 func == bpfr_pkg::FN_FLUSH && flush_hit)) begin
      data_idx <= data_idx + IDX_W'(1);
    end
    if (state == bpfr_pkg::S_SCAN && data_live) begin
      if (e_occ && e_page == page && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= data_idx;
      end
      if (!e_occ && !empty_found) begin
        empty_found <= 1'b1;
        empty_idx   <= data_idx;
      end
      if (e_pins == '0 && (!victim_found || e_rank < victim_rank)) begin
        victim_found <= 1'b1;
        victim_idx   <= data_idx;
        victim_rank  <= e_rank;
      end
    end
    if (state == bpfr_pkg::S_ACT) begin
      old_rank <= tgt_entry[R_LO +: RANK_W];
    end
  end

  // The target index and the rank it takes.
  always_comb begin
    if (func == bpfr_pkg::FN_INSPECT) begin
      tgt = IDX_W'(sel);
    end else if (hit_found) begin
      tgt = hit_idx;
    end else if (empty_found) begin
      tgt = empty_idx;
    end else begin
      tgt = victim_idx;
    end
    if (pin_fill) begin
      new_rank = RANK_W'(filled);
    end else begin
      new_rank = RANK_W'(filled - CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res <= '0;
    end else if (res_load) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/buffer_pool_frame_replacer_tb.sv
// ----------------------------------------------------------------------------
// buffer_pool_frame_replacer_tb: self-checking bench for the frame replacer
// Drives page requests over the input stream and predicts every result item
// with a behavioral frame table. Actual items are compared field by field, in
// order, across FIFO and LRU phases with varied idling and back pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_pool_frame_replacer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpfr_pkg::*;

  localparam int NFR = 16;
  localparam logic [FUNC_W-1:0] FN_RSVD6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RSVD7 = 3'd7;
  localparam logic [7:0] PIN_SAT = 8'hFF;

  // One result item, split into its fields.
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  frame_used;
    logic        wb_valid;
    logic [19:0] wb_page;
    logic        fetch_valid;
    logic [19:0] fetch_page;
    logic        occupied;
    logic [19:0] fpage;
    logic [7:0]  fpins;
    logic        fdirty;
    logic [31:0] reads;
    logic [31:0] writes;
  } pool_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_data = 1'b0;

  buffer_pool_frame_replacer u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow frame table that mirrors the block's state.
  logic [19:0] shadow_page [NFR];
  logic        shadow_occ  [NFR];
  logic [7:0]  shadow_pins [NFR];
  logic        shadow_dirty[NFR];
  logic [3:0]  shadow_rank [NFR];
  logic [4:0]  shadow_filled;
  logic [31:0] shadow_reads;
  logic [31:0] shadow_writes;
  logic        shadow_lru;

  logic [31:0]  request_queue[$];
  pool_result_t expected_results[$];
  int           error_count = 0;

  // Idling controls: rates and hold requests set by the stimulus process, hold counters by the hold-off process.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("FAIL");
    $finish;
  end

  function automatic pool_result_t blank_result();
    pool_result_t r;
    r = '0;
    r.reads = shadow_reads;
    r.writes = shadow_writes;
    return r;
  endfunction

  function automatic int lookup_page(logic [19:0] page);
    for (int i = 0; i < NFR; i++)
      if (shadow_occ[i] && shadow_page[i] == page) return i;
    return -1;
  endfunction

  // Moves frame f to the most recent rank, closing the gap it leaves.
  function automatic void make_newest(int f);
    for (int g = 0; g < NFR; g++)
      if (g != f && shadow_occ[g] && shadow_rank[g] > shadow_rank[f])
        shadow_rank[g] = shadow_rank[g] - 4'd1;
    shadow_rank[f] = 4'(shadow_filled - 5'd1);
  endfunction

  function automatic void predict_pin(logic [19:0] page);
    pool_result_t r;
    int f;
    f = lookup_page(page);
    if (f >= 0) begin
      if (shadow_pins[f] != PIN_SAT) shadow_pins[f]++;
      if (shadow_lru) make_newest(f);
      r = blank_result();
      r.frame_used = 4'(f);
      expected_results.push_back(r);
      return;
    end
    for (int i = 0; i < NFR; i++)
      if (!shadow_occ[i] && f < 0) f = i;
    r = '0;
    if (f >= 0) begin
      shadow_occ[f] = 1'b1;
      shadow_rank[f] = 4'(shadow_filled);
      shadow_filled++;
    end else begin
      // Victim is the unpinned frame of lowest rank.
      for (int i = 0; i < NFR; i++)
        if (shadow_pins[i] == 0 && (f < 0 || shadow_rank[i] < shadow_rank[f])) f = i;
      if (f < 0) begin
        r = blank_result();
        r.status = ST_NO_FRAME;
        expected_results.push_back(r);
        return;
      end
      if (shadow_dirty[f]) begin
        r.wb_valid = 1'b1;
        r.wb_page = shadow_page[f];
        shadow_writes++;
      end
      make_newest(f);
    end
    shadow_page[f] = page;
    shadow_pins[f] = 8'd1;
    shadow_dirty[f] = 1'b0;
    shadow_reads++;
    r.frame_used = 4'(f);
    r.fetch_valid = 1'b1;
    r.fetch_page = page;
    r.reads = shadow_reads;
    r.writes = shadow_writes;
    expected_results.push_back(r);
  endfunction

  // Works out the result items that one accepted request causes.
  function automatic void predict_request(logic [31:0] req);
    logic [2:0]  fn;
    logic [19:0] page;
    logic [3:0]  sel;
    pool_result_t r;
    int f;
    fn = req[2:0];
    page = req[22:3];
    sel = req[26:23];
    if (fn == FN_RSVD6 || fn == FN_RSVD7) return;
    if (fn == FN_FLUSH) begin
      for (int i = 0; i < NFR; i++) begin
        if (shadow_occ[i] && shadow_dirty[i] && shadow_pins[i] == 0) begin
          shadow_dirty[i] = 1'b0;
          shadow_writes++;
          r = blank_result();
          r.frame_used = 4'(i);
          r.wb_valid = 1'b1;
          r.wb_page = shadow_page[i];
          expected_results.push_back(r);
        end
      end
      return;
    end
    if (fn == FN_PIN) begin
      predict_pin(page);
      return;
    end
    r = blank_result();
    if (fn == FN_INSPECT) begin
      r.frame_used = sel;
      if (shadow_occ[sel]) begin
        r.occupied = 1'b1;
        r.fpage = shadow_page[sel];
        r.fpins = shadow_pins[sel];
        r.fdirty = shadow_dirty[sel];
      end
      expected_results.push_back(r);
      return;
    end
    f = lookup_page(page);
    if (f < 0) begin
      if (fn == FN_UNPIN) r.status = ST_MISSING;
      expected_results.push_back(r);
      return;
    end
    r.frame_used = 4'(f);
    if (fn == FN_UNPIN) begin
      if (shadow_pins[f] != 0) shadow_pins[f]--;
    end else if (fn == FN_DIRTY) begin
      shadow_dirty[f] = 1'b1;
    end else begin
      shadow_dirty[f] = 1'b0;
      shadow_writes++;
      r.wb_valid = 1'b1;
      r.wb_page = shadow_page[f];
      r.writes = shadow_writes;
    end
    expected_results.push_back(r);
  endfunction

  // Request driver: presents queued requests, predicting each one as the
  // block takes it.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) predict_request(s_axis_tdata);
      if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= request_queue.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here and armed by the stimulus process.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_served + 1;
      hold_left <= 600;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: mismatch in %s: expected %0h, actual %0h", $realtime, name, want, got);
      error_count++;
    end
  endtask

  // Result monitor: every accepted item is held against the oldest prediction.
  always @(posedge clk) begin
    pool_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[1:0];
      got.frame_used = m_axis_tdata[5:2];
      got.wb_valid = m_axis_tdata[6];
      got.wb_page = m_axis_tdata[26:7];
      got.fetch_valid = m_axis_tdata[27];
      got.fetch_page = m_axis_tdata[47:28];
      got.occupied = m_axis_tdata[48];
      got.fpage = m_axis_tdata[68:49];
      got.fpins = m_axis_tdata[76:69];
      got.fdirty = m_axis_tdata[77];
      got.reads = m_axis_tdata[109:78];
      got.writes = m_axis_tdata[141:110];
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result item, actual %h", $realtime, m_axis_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("frame_used", 32'(want.frame_used), 32'(got.frame_used));
        check_field("writeback_valid", 32'(want.wb_valid), 32'(got.wb_valid));
        check_field("writeback_page", 32'(want.wb_page), 32'(got.wb_page));
        check_field("fetch_valid", 32'(want.fetch_valid), 32'(got.fetch_valid));
        check_field("fetch_page", 32'(want.fetch_page), 32'(got.fetch_page));
        check_field("frame_occupied", 32'(want.occupied), 32'(got.occupied));
        check_field("frame_page", 32'(want.fpage), 32'(got.fpage));
        check_field("frame_pins", 32'(want.fpins), 32'(got.fpins));
        check_field("frame_dirty", 32'(want.fdirty), 32'(got.fdirty));
        check_field("io_reads", want.reads, got.reads);
        check_field("io_writes", want.writes, got.writes);
      end
    end
  end

  function automatic logic [31:0] pack_request(logic [2:0] fn, logic [19:0] page,
                                               logic [3:0] sel);
    return {5'b0, sel, page, fn};
  endfunction

  // Waits until every request is taken and every result has come back.
  task automatic wait_drained();
    while (request_queue.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  // Flushes with no dirty frame give no result, so settle a while before a
  // policy write.
  task automatic write_policy(logic lru);
    wait_drained();
    repeat (60) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= lru;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_lru = lru;
  endtask

  // Random requests over a small page set, so hits, evictions and pins stack.
  task automatic queue_random(int count);
    logic [19:0] pool [24];
    logic [2:0]  fn;
    logic [19:0] page;
    int pick;
    foreach (pool[i]) pool[i] = 20'($urandom_range(0, 20'hFFFFF));
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 32) fn = FN_PIN;
      else if (pick < 62) fn = FN_UNPIN;
      else if (pick < 76) fn = FN_DIRTY;
      else if (pick < 83) fn = FN_FORCE;
      else if (pick < 89) fn = FN_FLUSH;
      else if (pick < 98) fn = FN_INSPECT;
      else fn = pick[0] ? FN_RSVD6 : FN_RSVD7;
      if ($urandom_range(9) < 8) page = pool[$urandom_range(23)];
      else page = 20'($urandom_range(0, 20'hFFFFF));
      request_queue.push_back(pack_request(fn, page, 4'($urandom_range(15))));
    end
  endtask

  initial begin
    for (int i = 0; i < NFR; i++) begin
      shadow_page[i] = '0;
      shadow_occ[i] = 1'b0;
      shadow_pins[i] = '0;
      shadow_dirty[i] = 1'b0;
      shadow_rank[i] = '0;
    end
    shadow_filled = '0;
    shadow_reads = '0;
    shadow_writes = '0;
    shadow_lru = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part under FIFO: fill every frame, hit the full-and-pinned
    // case, then the not-resident, zero-pin and reserved-code cases.
    write_policy(1'b0);
    request_queue.push_back(pack_request(FN_PIN, 20'h00000, 4'd0));
    request_queue.push_back(pack_request(FN_PIN, 20'hFFFFF, 4'd15));
    for (int i = 2; i < NFR; i++)
      request_queue.push_back(pack_request(FN_PIN, 20'(i * 4099), 4'd0));
    request_queue.push_back(pack_request(FN_PIN, 20'h55555, 4'd0));
    request_queue.push_back(pack_request(FN_UNPIN, 20'hAAAAA, 4'd0));
    request_queue.push_back(pack_request(FN_DIRTY, 20'hAAAAA, 4'd0));
    request_queue.push_back(pack_request(FN_FORCE, 20'hAAAAA, 4'd0));
    request_queue.push_back(pack_request(FN_RSVD6, 20'h00000, 4'd0));
    request_queue.push_back(pack_request(FN_RSVD7, 20'hFFFFF, 4'd15));
    request_queue.push_back(pack_request(FN_UNPIN, 20'h00000, 4'd0));
    request_queue.push_back(pack_request(FN_UNPIN, 20'h00000, 4'd0));
    request_queue.push_back(pack_request(FN_DIRTY, 20'h00000, 4'd0));
    request_queue.push_back(pack_request(FN_INSPECT, 20'h00000, 4'd0));
    request_queue.push_back(pack_request(FN_INSPECT, 20'h00000, 4'd15));
    request_queue.push_back(pack_request(FN_FORCE, 20'hFFFFF, 4'd0));
    request_queue.push_back(pack_request(FN_FLUSH, 20'h00000, 4'd0));
    request_queue.push_back(pack_request(FN_DIRTY, 20'h00000, 4'd0));
    request_queue.push_back(pack_request(FN_PIN, 20'h55555, 4'd0));

    // LRU with no idling; pin one page repeatedly along the way.
    write_policy(1'b1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random(30);
    for (int i = 0; i < 20; i++)
      request_queue.push_back(pack_request(FN_PIN, 20'h0F0F0, 4'd0));
    request_queue.push_back(pack_request(FN_INSPECT, 20'h0, 4'd0));
    queue_random(10);

    // FIFO with a sparse sender.
    write_policy(1'b0);
    send_idle_pct = 84;
    recv_stall_pct = 0;
    queue_random(40);

    // LRU with a stalling receiver and one long hold-off while requests wait.
    write_policy(1'b1);
    send_idle_pct = 0;
    recv_stall_pct = 84;
    queue_random(40);
    hold_requests = hold_requests + 1;

    // FIFO with both sides idling, and a sender pause until all results are in.
    write_policy(1'b0);
    send_idle_pct = 21;
    recv_stall_pct = 21;
    queue_random(20);
    wait_drained();
    queue_random(20);

    wait_drained();
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
